// File: sv/hkr_pkg.sv
// Shared types, constants and the usage translation table for the keyboard report block.
`timescale 1ns / 1ps

package hkr_pkg;

    // Number of key slot fields carried in one report item
    localparam int MAX_SLOTS          = 5;
    localparam int KEY_SLOTS_DEFAULT  = 5;
    localparam int MOD_COUNT          = 8;
    localparam int EV_COUNT_DEFAULT   = MOD_COUNT + 2 * KEY_SLOTS_DEFAULT;

    localparam logic       EV_PRESS   = 1'b0;
    localparam logic       EV_RELEASE = 1'b1;
    localparam logic [7:0] NO_KEY     = 8'hff;
    localparam logic [7:0] EMPTY_SLOT = 8'h00;
    localparam logic [7:0] ROM_SPAN   = 8'd112;

    typedef struct packed {
        logic [7:0] modifier_bits;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] check_byte;
    } report_t;

    typedef struct packed {
        logic       event_kind;
        logic [7:0] key_code;
        logic       last_event;
    } key_event_t;

    // What one slot lane found: a press for its new usage, a release for its old one
    typedef struct packed {
        logic       press_valid;
        logic [7:0] press_code;
        logic       release_valid;
        logic [7:0] release_code;
    } lane_result_t;

    // Modifier scan order: lshift, lctrl, lmeta, lalt, ralt, rmeta, rctrl, rshift
    localparam logic [7:0] MOD_MASK [0:MOD_COUNT-1] = '{
        8'h02, 8'h01, 8'h08, 8'h04, 8'h40, 8'h80, 8'h10, 8'h20
    };
    localparam logic [7:0] MOD_CODE [0:MOD_COUNT-1] = '{
        8'd42, 8'd29, 8'd125, 8'd56, 8'd100, 8'd126, 8'd97, 8'd54
    };

    localparam logic [7:0] USAGE_ROM [0:111] = '{
        8'hff, 8'hff, 8'hff, 8'hff, 8'h1e, 8'h30, 8'h2e, 8'h20,
        8'h12, 8'h21, 8'h22, 8'h23, 8'h17, 8'h24, 8'h25, 8'h26,
        8'h32, 8'h31, 8'h18, 8'h19, 8'h10, 8'h13, 8'h1f, 8'h14,
        8'h16, 8'h2f, 8'h11, 8'h2d, 8'h15, 8'h2c, 8'h02, 8'h03,
        8'h04, 8'h05, 8'h06, 8'h07, 8'h08, 8'h09, 8'h0a, 8'h0b,
        8'h1c, 8'h01, 8'h0e, 8'h0f, 8'h39, 8'hff, 8'h2b, 8'h1a,
        8'h1b, 8'hff, 8'h2b, 8'h27, 8'h28, 8'hff, 8'h33, 8'h34,
        8'h35, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
        8'hff, 8'hff, 8'hff, 8'hff, 8'h62, 8'hff, 8'h4a, 8'hff,
        8'h60, 8'h4f, 8'h50, 8'h51, 8'h4b, 8'h4c, 8'h4e, 8'h47,
        8'h48, 8'h49, 8'h52, 8'h53, 8'h56, 8'hff, 8'hff, 8'h49,
        8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff
    };

    function automatic logic [7:0] translate(input logic [7:0] usage);
        logic [7:0] code;
        code = NO_KEY;
        if (usage < ROM_SPAN) begin
            code = USAGE_ROM[usage[6:0]];
        end
        return code;
    endfunction

endpackage

// File: sv/hid_keyboard_report_to_key_events_top.sv
// Top level: turns boot keyboard reports into ordered key press and release items.
`timescale 1ns / 1ps

// Path: a report's events are registered in the pending event buffer, then moved one at a time
//   into the single output register that drives m_data.
// Throughput: one event item per cycle while m_ready is high; a report with N events (N up to
//   8 + 2*slots, 18 by default) holds the input while the single output register drains the
//   pending event buffer. The next report is taken as the last event leaves.
// Reset (aresetn low, synchronous): clear stored modifiers and keys, drop pending events.

module hid_keyboard_report_to_key_events_top #(
    parameter int KEY_SLOTS = hkr_pkg::KEY_SLOTS_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  hkr_pkg::report_t    s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output hkr_pkg::key_event_t m_data
);

    // Only the first slots are looked at; the report carries at most MAX_SLOTS
    localparam int SLOT_USED = (KEY_SLOTS > hkr_pkg::MAX_SLOTS) ? hkr_pkg::MAX_SLOTS :
                               ((KEY_SLOTS < 1) ? 1 : KEY_SLOTS);
    localparam int MODS      = hkr_pkg::MOD_COUNT;
    localparam int EV_COUNT  = MODS + 2 * SLOT_USED;

    logic [7:0]                    prev_mods_reg;
    logic [7:0]                    prev_mods_next;
    logic [SLOT_USED-1:0][7:0]     prev_keys_reg;
    logic [SLOT_USED-1:0][7:0]     prev_keys_next;

    logic [hkr_pkg::MAX_SLOTS-1:0][7:0] all_keys;
    logic [SLOT_USED-1:0][7:0]     new_keys;
    logic                          accept;
    logic                          report_ok;
    logic                          merge_ready;

    hkr_pkg::lane_result_t         lane_res [SLOT_USED];
    logic [EV_COUNT-1:0]           ev_valid;
    logic [EV_COUNT-1:0]           ev_kind;
    logic [EV_COUNT-1:0][7:0]      ev_code;

    assign all_keys = {s_data.key_slot_4, s_data.key_slot_3, s_data.key_slot_2,
                       s_data.key_slot_1, s_data.key_slot_0};
    assign new_keys = all_keys[SLOT_USED-1:0];

    assign s_ready   = merge_ready;
    assign accept    = s_valid && merge_ready;
    assign report_ok = (s_data.check_byte == 8'h00);

    // Modifier edges: press when the bit rose, release when it fell
    for (genvar m = 0; m < MODS; m++) begin : g_mod
        assign ev_valid[m] = report_ok && (((s_data.modifier_bits ^ prev_mods_reg)
                                            & hkr_pkg::MOD_MASK[m]) != 8'h00);
        assign ev_kind[m]  = ((prev_mods_reg & hkr_pkg::MOD_MASK[m]) != 8'h00) ?
                             hkr_pkg::EV_RELEASE : hkr_pkg::EV_PRESS;
        assign ev_code[m]  = hkr_pkg::MOD_CODE[m];
    end

    // One lane per key slot; presses fill the middle of the vector, releases the top
    for (genvar g = 0; g < SLOT_USED; g++) begin : g_lane
        hkr_lane #(
            .SLOTS (SLOT_USED),
            .LANE  (g)
        ) u_lane (
            .new_keys  (new_keys),
            .prev_keys (prev_keys_reg),
            .result    (lane_res[g])
        );

        assign ev_valid[MODS + g]             = report_ok && lane_res[g].press_valid;
        assign ev_kind[MODS + g]              = hkr_pkg::EV_PRESS;
        assign ev_code[MODS + g]              = lane_res[g].press_code;
        assign ev_valid[MODS + SLOT_USED + g] = report_ok && lane_res[g].release_valid;
        assign ev_kind[MODS + SLOT_USED + g]  = hkr_pkg::EV_RELEASE;
        assign ev_code[MODS + SLOT_USED + g]  = lane_res[g].release_code;
    end

    hkr_merge #(
        .EV_COUNT (EV_COUNT)
    ) u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (accept),
        .ev_valid (ev_valid),
        .ev_kind  (ev_kind),
        .ev_code  (ev_code),
        .in_ready (merge_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

    // Advance the stored report only on a good item; hold it across a bad one
    always_comb begin
        prev_mods_next = prev_mods_reg;
        prev_keys_next = prev_keys_reg;
        if (accept && report_ok) begin
            prev_mods_next = s_data.modifier_bits;
            prev_keys_next = new_keys;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mods_reg <= '0;
            prev_keys_reg <= '0;
        end else begin
            prev_mods_reg <= prev_mods_next;
            prev_keys_reg <= prev_keys_next;
        end
    end

`ifndef SYNTHESIS
    // A bad report leaves the stored state untouched
    a_bad_report_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_data.check_byte != 8'h00))
        |=> ($stable(prev_mods_reg) && $stable(prev_keys_reg)))
        else $error("stored state changed on a bad report");

    // While a non-final event is stalled, more events wait, so no new report is taken
    a_no_accept_mid_report: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.last_event && !m_ready) |-> !s_ready)
        else $error("report taken while events of the previous one remain");

    // Reset drops the output
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("output valid after reset");
`endif

endmodule

// File: sv/hkr_lane.sv
// One key slot lane: finds the press of its new usage and the release of its old usage.
`timescale 1ns / 1ps

module hkr_lane #(
    parameter int SLOTS = hkr_pkg::KEY_SLOTS_DEFAULT,
    parameter int LANE  = 0
) (
    input  logic [SLOTS-1:0][7:0] new_keys,
    input  logic [SLOTS-1:0][7:0] prev_keys,
    output hkr_pkg::lane_result_t result
);

    logic       held_new;
    logic       held_old;
    logic [7:0] press_code;
    logic [7:0] release_code;

    always_comb begin
        held_new = 1'b0;
        held_old = 1'b0;
        for (int j = 0; j < SLOTS; j++) begin
            if (prev_keys[j] == new_keys[LANE]) begin
                held_new = 1'b1;
            end
            if (new_keys[j] == prev_keys[LANE]) begin
                held_old = 1'b1;
            end
        end
    end

    assign press_code   = hkr_pkg::translate(new_keys[LANE]);
    assign release_code = hkr_pkg::translate(prev_keys[LANE]);

    assign result.press_valid   = (new_keys[LANE] != hkr_pkg::EMPTY_SLOT) && !held_new
                                  && (press_code != hkr_pkg::NO_KEY);
    assign result.press_code    = press_code;
    assign result.release_valid = (prev_keys[LANE] != hkr_pkg::EMPTY_SLOT) && !held_old
                                  && (release_code != hkr_pkg::NO_KEY);
    assign result.release_code  = release_code;

endmodule

// File: sv/hkr_merge.sv
// Pending event buffer and output register: drains all events in order, one per cycle unless m_ready stalls it.
`timescale 1ns / 1ps

module hkr_merge #(
    parameter int EV_COUNT = hkr_pkg::EV_COUNT_DEFAULT
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      load,
    input  logic [EV_COUNT-1:0]       ev_valid,
    input  logic [EV_COUNT-1:0]       ev_kind,
    input  logic [EV_COUNT-1:0][7:0]  ev_code,
    output logic                      in_ready,
    output logic                      m_valid,
    input  logic                      m_ready,
    output hkr_pkg::key_event_t       m_data
);

    logic [EV_COUNT-1:0]      pend_mask_reg;
    logic [EV_COUNT-1:0]      pend_mask_next;
    logic [EV_COUNT-1:0]      pend_kind_reg;
    logic [EV_COUNT-1:0][7:0] pend_code_reg;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    hkr_pkg::key_event_t      out_data_reg;
    hkr_pkg::key_event_t      out_data_next;

    logic [EV_COUNT-1:0]      pick;
    logic [EV_COUNT-1:0]      rest;
    logic [EV_COUNT-1:0]      mask_after;
    logic [7:0]               pick_code;
    logic                     pick_kind;
    logic                     load_out;

    // Lowest pending position goes first
    assign pick = pend_mask_reg & (~pend_mask_reg + EV_COUNT'(1));
    assign rest = pend_mask_reg & ~pick;

    always_comb begin
        pick_code = '0;
        pick_kind = 1'b0;
        for (int i = 0; i < EV_COUNT; i++) begin
            pick_code = pick_code | ({8{pick[i]}} & pend_code_reg[i]);
            pick_kind = pick_kind | (pick[i] & pend_kind_reg[i]);
        end
    end

    assign load_out   = (|pend_mask_reg) && (!out_valid_reg || m_ready);
    assign mask_after = load_out ? rest : pend_mask_reg;
    assign in_ready   = (mask_after == '0);

    always_comb begin
        pend_mask_next = load ? ev_valid : mask_after;
        if (load_out) begin
            out_valid_next           = 1'b1;
            out_data_next.event_kind = pick_kind;
            out_data_next.key_code   = pick_code;
            out_data_next.last_event = (rest == '0);
        end else begin
            out_valid_next = out_valid_reg && !m_ready;
            out_data_next  = out_data_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_mask_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_mask_reg <= pend_mask_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            pend_kind_reg <= ev_kind;
            pend_code_reg <= ev_code;
        end
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
